### design/srt_pkg.sv
// Package for the sort and median unit.
// Holds the shared widths, the controller state type, the cell operation codes and the cell link type.
// No dependencies.
`default_nettype none
package srt_pkg;
	localparam int DATA_W        = 32;
	localparam int RANK_W        = 6;
	localparam int MED_W         = 33;
	localparam int MAX_ITEMS_DEF = 64;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} srt_state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	// Link between neighboring cells.
	typedef struct packed {
		logic                     valid;
		logic                     gt;
		logic signed [DATA_W-1:0] value;
	} cell_t;
endpackage
`default_nettype wire

### design/srt_in_if.sv
// Input channel interface: valid/ready handshake carrying one sample per transfer.
// Depends on srt_pkg.
`default_nettype none
interface srt_in_if;
	import srt_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample;
	logic                     final_item;

	modport source (output valid, output sample, output final_item, input ready);
	modport sink (input valid, input sample, input final_item, output ready);
endinterface
`default_nettype wire

### design/srt_out_if.sv
// Output channel interface: valid/ready handshake carrying one sorted result per transfer.
// Depends on srt_pkg.
`default_nettype none
interface srt_out_if;
	import srt_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sorted_value;
	logic [RANK_W-1:0]        rank;
	logic                     run_end;
	logic signed [MED_W-1:0]  median_doubled;
	logic                     overflowed;

	modport source (output valid, output sorted_value, output rank, output run_end,
		output median_doubled, output overflowed, input ready);
	modport sink (input valid, input sorted_value, input rank, input run_end,
		input median_doubled, input overflowed, output ready);
endinterface
`default_nettype wire

### design/sort_and_median_unit.sv
// Sort and median unit: loads one sample per cycle into a sorted insertion chain of MaxItems cells.
// After the final item, results leave cell 0 at one per cycle while the sink is ready: the
// controller enters the drain state and each result is registered in the output stage. Input is held off
// during the drain. Asynchronous reset empties the chain and clears the count and overflow flag.
// Depends on srt_pkg, srt_in_if, srt_out_if and srt_cell.
`default_nettype none
module sort_and_median_unit #(
	parameter int MaxItems = srt_pkg::MAX_ITEMS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	srt_in_if.sink     samples,
	srt_out_if.source  results
);
	import srt_pkg::*;

	localparam int CW = $clog2(MaxItems + 1);
	localparam int IW = $clog2(MaxItems);

	srt_state_t state_q, state_d;
	cell_op_t   op;
	cell_t      link [MaxItems];
	cell_t      edge_lo, edge_hi;

	logic [CW-1:0]            fill_q;
	logic                     drop_q;
	logic [IW-1:0]            rank_q;
	logic signed [DATA_W-1:0] prev_q;
	logic signed [MED_W-1:0]  med_q;

	logic                     ovld_q;
	logic signed [DATA_W-1:0] oval_q;
	logic [RANK_W-1:0]        orank_q;
	logic                     oend_q;
	logic signed [MED_W-1:0]  omed_q;
	logic                     oovf_q;

	logic                     accept_in, ins, pop, last, at_half;
	logic [CW-1:0]            n_minus1, half;
	logic signed [DATA_W-1:0] head;
	logic signed [MED_W-1:0]  med_now, med_sel;

	assign edge_lo = '{valid: 1'b0, gt: 1'b0, value: '0};
	assign edge_hi = '{valid: 1'b0, gt: 1'b1, value: '0};

	for (genvar i = 0; i < MaxItems; i++) begin : g_cell
		srt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.op    (op),
			.x     (samples.sample),
			.left  ((i == 0) ? edge_lo : link[(i == 0) ? 0 : i - 1]),
			.right ((i == MaxItems - 1) ? edge_hi : link[(i == MaxItems - 1) ? i : i + 1]),
			.own   (link[i])
		);
	end

	assign head      = link[0].value;
	assign accept_in = samples.valid && samples.ready;
	assign ins       = accept_in && (fill_q != CW'(MaxItems));
	assign pop       = (state_q == ST_DRAIN) && (!ovld_q || results.ready);
	assign n_minus1  = fill_q - CW'(1);
	assign half      = fill_q >> 1;
	assign last      = (rank_q == n_minus1[IW-1:0]);
	assign at_half   = (rank_q == half[IW-1:0]);

	// odd count: twice the middle value; even: sum of the two middle values
	assign med_now = fill_q[0] ? (MED_W'(head) <<< 1) : (MED_W'(prev_q) + MED_W'(head));
	assign med_sel = at_half ? med_now : med_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (accept_in && samples.final_item) state_d = ST_DRAIN;
			ST_DRAIN: if (pop && last) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		samples.ready = (state_q == ST_LOAD);
		if (ins) begin
			op = CELL_INSERT;
		end else if (pop) begin
			op = CELL_SHIFT;
		end else begin
			op = CELL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			drop_q  <= 1'b0;
			rank_q  <= '0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && last) begin
				fill_q <= '0;
				drop_q <= 1'b0;
			end else begin
				if (ins) fill_q <= fill_q + CW'(1);
				if (accept_in && !ins) drop_q <= 1'b1;
			end
			if (pop) begin
				rank_q <= last ? '0 : rank_q + IW'(1);
				ovld_q <= 1'b1;
			end else if (results.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prev_q  <= head;
			oval_q  <= head;
			orank_q <= RANK_W'(rank_q);
			oend_q  <= last;
			omed_q  <= last ? med_sel : '0;
			oovf_q  <= drop_q;
			if (at_half) med_q <= med_now;
		end
	end

	assign results.valid          = ovld_q;
	assign results.sorted_value   = oval_q;
	assign results.rank           = orank_q;
	assign results.run_end        = oend_q;
	assign results.median_doubled = omed_q;
	assign results.overflowed     = oovf_q;
endmodule
`default_nettype wire

### design/srt_cell.sv
// One cell of the insertion chain: holds one value and keeps the chain sorted ascending.
// Depends on srt_pkg.
`default_nettype none
module srt_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire srt_pkg::cell_op_t                op,
	input  wire logic signed [srt_pkg::DATA_W-1:0] x,
	input  wire srt_pkg::cell_t                   left,
	input  wire srt_pkg::cell_t                   right,
	output srt_pkg::cell_t                        own
);
	import srt_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     gt;

	// empty cells count as greater; ties keep arrival order
	assign gt = !valid_q || (value_q > x);

	assign own = '{valid: valid_q, gt: gt, value: value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				CELL_INSERT: begin
					if (left.gt) begin
						valid_q <= left.valid;
					end else if (gt) begin
						valid_q <= 1'b1;
					end
				end
				CELL_SHIFT: valid_q <= right.valid;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: begin
				if (left.gt) begin
					value_q <= left.value;
				end else if (gt) begin
					value_q <= x;
				end
			end
			CELL_SHIFT: value_q <= right.value;
			default: ;
		endcase
	end
endmodule
`default_nettype wire
